FILE: design/ttw_pkg.sv
// shared constants, types and slot mapping for the three-level timer wheel
package ttw_pkg;

    localparam int MAX_TASKS = 64;
    localparam int TASK_W    = $clog2(MAX_TASKS);
    localparam int LINK_W    = 7;
    localparam int CNT_W     = 7;

    localparam int W1_BITS   = 12;
    localparam int W2_BITS   = 10;
    localparam int W1_SLOTS  = 1 << W1_BITS;
    localparam int W2_SLOTS  = 1 << W2_BITS;
    localparam int W3_SLOTS  = 64;
    localparam int NSLOTS    = W1_SLOTS + W2_SLOTS + W3_SLOTS + 1;
    localparam int SLOT_W    = $clog2(NSLOTS + 1);
    localparam int HS_AW     = $clog2(NSLOTS);

    localparam logic [LINK_W-1:0] NIL          = {LINK_W{1'b1}};
    localparam logic [SLOT_W-1:0] FOREVER_SLOT = SLOT_W'(NSLOTS - 1);
    localparam logic [SLOT_W-1:0] NO_SLOT      = SLOT_W'(NSLOTS);
    localparam logic [HS_AW-1:0]  LAST_SLOT    = HS_AW'(NSLOTS - 1);

    localparam logic [1:0] OP_PAUSE   = 2'd0;
    localparam logic [1:0] OP_RUN     = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_ADVANCE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAR    = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    localparam logic [1:0] FLG_NONE   = 2'b00;
    localparam logic [1:0] FLG_PAUSED = 2'b01;
    localparam logic [1:0] FLG_RUN    = 2'b11;

    localparam logic [1:0] PH_W3 = 2'd0;
    localparam logic [1:0] PH_W2 = 2'd1;
    localparam logic [1:0] PH_W1 = 2'd2;

    localparam logic [4:0] A_NONE     = 5'd0;
    localparam logic [4:0] A_CLEAR    = 5'd1;
    localparam logic [4:0] A_ACCEPT   = 5'd2;
    localparam logic [4:0] A_DECODE   = 5'd3;
    localparam logic [4:0] A_UNL_RD   = 5'd4;
    localparam logic [4:0] A_UNL_WR   = 5'd5;
    localparam logic [4:0] A_PAUSE_WR = 5'd6;
    localparam logic [4:0] A_FILE     = 5'd7;
    localparam logic [4:0] A_APP_B    = 5'd8;
    localparam logic [4:0] A_APP_C    = 5'd9;
    localparam logic [4:0] A_WAKE_ID  = 5'd10;
    localparam logic [4:0] A_REMOVE   = 5'd11;
    localparam logic [4:0] A_LIST_RD  = 5'd12;
    localparam logic [4:0] A_LIST_CLR = 5'd13;
    localparam logic [4:0] A_LOOP     = 5'd14;
    localparam logic [4:0] A_MIG_T    = 5'd15;
    localparam logic [4:0] A_MIG_NEXT = 5'd16;
    localparam logic [4:0] A_WAKE_T   = 5'd17;
    localparam logic [4:0] A_BASE_INC = 5'd18;
    localparam logic [4:0] A_DONE     = 5'd19;
    localparam logic [4:0] A_EMPTY    = 5'd20;
    localparam logic [4:0] A_EM_RD    = 5'd21;
    localparam logic [4:0] A_EM_WR    = 5'd22;

    typedef struct packed {
        logic [4:0] act;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       valid_id;
        logic       present;
        logic       running;
        logic       file_past;
        logic       file_noslot;
        logic       tl_valid;
        logic       loop_ok;
        logic       s1_zero;
        logic       s2_zero;
        logic       s3_ok;
        logic       out_free;
        logic       woke_none;
        logic       emit_last;
        logic       clear_done;
    } stat_t;

    function automatic logic [SLOT_W-1:0] slot_for(input logic [31:0] w, input logic [31:0] b);
        logic [SLOT_W-1:0] s;
        if (w == 32'd0)
            s = FOREVER_SLOT;
        else if (w[31:W1_BITS] == b[31:W1_BITS])
            s = SLOT_W'(w[W1_BITS-1:0]);
        else if (w[31:W1_BITS+W2_BITS] == b[31:W1_BITS+W2_BITS])
            s = SLOT_W'(W1_SLOTS) + SLOT_W'(w[W1_BITS+W2_BITS-1:W1_BITS]);
        else if ((w >> (W1_BITS + W2_BITS)) < 32'(W3_SLOTS))
            s = SLOT_W'(W1_SLOTS + W2_SLOTS) + SLOT_W'(w >> (W1_BITS + W2_BITS));
        else
            s = NO_SLOT;
        return s;
    endfunction

endpackage

FILE: design/ttw_ram.sv
// generic single-port ram with registered read
module ttw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/ttw_ctrl.sv
// sequencer that steps each request through list edits, migration and result output
module ttw_ctrl
    import ttw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DECODE   = 5'd2;
    localparam logic [4:0] S_UNL_RD   = 5'd3;
    localparam logic [4:0] S_UNL_WR   = 5'd4;
    localparam logic [4:0] S_PAUSE_WR = 5'd5;
    localparam logic [4:0] S_FILE     = 5'd6;
    localparam logic [4:0] S_APP_B    = 5'd7;
    localparam logic [4:0] S_APP_C    = 5'd8;
    localparam logic [4:0] S_WAKE_ID  = 5'd9;
    localparam logic [4:0] S_REMOVE   = 5'd10;
    localparam logic [4:0] S_LIST_RD  = 5'd11;
    localparam logic [4:0] S_LIST_CLR = 5'd12;
    localparam logic [4:0] S_LOOP     = 5'd13;
    localparam logic [4:0] S_MIG_T    = 5'd14;
    localparam logic [4:0] S_MIG_NEXT = 5'd15;
    localparam logic [4:0] S_WAKE_T   = 5'd16;
    localparam logic [4:0] S_BASE_INC = 5'd17;
    localparam logic [4:0] S_DONE     = 5'd18;
    localparam logic [4:0] S_EMPTY    = 5'd19;
    localparam logic [4:0] S_EM_RD    = 5'd20;
    localparam logic [4:0] S_EM_WR    = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [4:0] file_ret;
    logic [4:0] unl_ret;

    assign in_stall = (state_reg != S_IDLE);
    assign file_ret = (st.op == OP_PAUSE) ? S_DONE : S_MIG_NEXT;

    always_comb
    begin
        unique case (st.op)
            OP_PAUSE: unl_ret = S_PAUSE_WR;
            OP_RUN:   unl_ret = S_WAKE_ID;
            default:  unl_ret = S_REMOVE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.act    = A_NONE;
        cmd.phase  = phase_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.act = A_CLEAR;
                if (st.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act    = A_ACCEPT;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.act = A_DECODE;
                unique case (st.op)
                    OP_PAUSE:
                    begin
                        if (!st.present)
                            state_next = S_DONE;
                        else if (st.running)
                            state_next = S_PAUSE_WR;
                        else
                            state_next = S_UNL_RD;
                    end
                    OP_RUN:
                    begin
                        if (!st.valid_id)
                            state_next = S_DONE;
                        else if (!st.present)
                            state_next = S_WAKE_ID;
                        else if (!st.running)
                            state_next = S_UNL_RD;
                        else
                            state_next = S_DONE;
                    end
                    OP_REMOVE:
                    begin
                        if (!st.present)
                            state_next = S_DONE;
                        else if (st.running)
                            state_next = S_REMOVE;
                        else
                            state_next = S_UNL_RD;
                    end
                    default:
                    begin
                        state_next = S_LIST_RD;
                        if (!st.s1_zero)
                            phase_next = PH_W1;
                        else if (st.s2_zero && st.s3_ok)
                            phase_next = PH_W3;
                        else
                            phase_next = PH_W2;
                    end
                endcase
            end
            S_UNL_RD:
            begin
                cmd.act    = A_UNL_RD;
                state_next = S_UNL_WR;
            end
            S_UNL_WR:
            begin
                cmd.act    = A_UNL_WR;
                state_next = unl_ret;
            end
            S_PAUSE_WR:
            begin
                cmd.act    = A_PAUSE_WR;
                state_next = S_FILE;
            end
            S_FILE:
            begin
                cmd.act = A_FILE;
                if (st.file_past || st.file_noslot)
                    state_next = file_ret;
                else
                    state_next = S_APP_B;
            end
            S_APP_B:
            begin
                cmd.act    = A_APP_B;
                state_next = st.tl_valid ? S_APP_C : file_ret;
            end
            S_APP_C:
            begin
                cmd.act    = A_APP_C;
                state_next = file_ret;
            end
            S_WAKE_ID:
            begin
                cmd.act    = A_WAKE_ID;
                state_next = S_DONE;
            end
            S_REMOVE:
            begin
                cmd.act    = A_REMOVE;
                state_next = S_DONE;
            end
            S_LIST_RD:
            begin
                cmd.act    = A_LIST_RD;
                state_next = S_LIST_CLR;
            end
            S_LIST_CLR:
            begin
                cmd.act    = A_LIST_CLR;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                cmd.act = A_LOOP;
                if (st.loop_ok)
                    state_next = (phase_reg == PH_W1) ? S_WAKE_T : S_MIG_T;
                else if (phase_reg == PH_W3)
                begin
                    phase_next = PH_W2;
                    state_next = S_LIST_RD;
                end
                else if (phase_reg == PH_W2)
                begin
                    phase_next = PH_W1;
                    state_next = S_LIST_RD;
                end
                else
                    state_next = S_BASE_INC;
            end
            S_MIG_T:
            begin
                cmd.act    = A_MIG_T;
                state_next = S_FILE;
            end
            S_MIG_NEXT:
            begin
                cmd.act    = A_MIG_NEXT;
                state_next = S_LOOP;
            end
            S_WAKE_T:
            begin
                cmd.act    = A_WAKE_T;
                state_next = S_LOOP;
            end
            S_BASE_INC:
            begin
                cmd.act    = A_BASE_INC;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.act    = A_DONE;
                state_next = st.woke_none ? S_EMPTY : S_EM_RD;
            end
            S_EMPTY:
            begin
                cmd.act = A_EMPTY;
                if (st.out_free)
                    state_next = S_IDLE;
            end
            S_EM_RD:
            begin
                cmd.act    = A_EM_RD;
                state_next = S_EM_WR;
            end
            S_EM_WR:
            begin
                cmd.act = A_EM_WR;
                if (st.out_free)
                    state_next = st.emit_last ? S_IDLE : S_EM_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_W1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: design/ttw_dpath.sv
// slot and task memories, working registers and the result register
module ttw_dpath
    import ttw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               st,
    input  logic [1:0]          opcode,
    input  logic [TASK_W-1:0]   task_id,
    input  logic [31:0]         wake_time,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TASK_W-1:0]   woken_task,
    output logic                woken,
    output logic [1:0]          status,
    output logic [CNT_W-1:0]    paused_count,
    output logic [31:0]         current_base,
    output logic                last
);

    // control state
    logic [HS_AW-1:0]     clr_reg;
    logic [31:0]          base_reg;
    logic [CNT_W-1:0]     held_reg;
    logic [CNT_W-1:0]     wn_reg;
    logic [MAX_TASKS-1:0] fv_reg;
    logic                 ov_reg;
    // working payload
    logic [1:0]           op_reg;
    logic [LINK_W-1:0]    cur_reg;
    logic [LINK_W-1:0]    nxt_reg;
    logic [LINK_W-1:0]    tl_reg;
    logic [31:0]          win_reg;
    logic [31:0]          w_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [1:0]           stat_reg;
    logic [CNT_W-1:0]     guard_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [TASK_W-1:0]    otask_reg;
    logic                 owoken_reg;
    logic                 olast_reg;

    // ram ports
    logic                 head_we, tail_we, nxt_we, prv_we, wake_we, idx_we, flg_we, woke_we;
    logic [HS_AW-1:0]     head_addr, tail_addr;
    logic [LINK_W-1:0]    head_wd, tail_wd, head_q, tail_q;
    logic [TASK_W-1:0]    nxt_addr, prv_addr, wake_addr, idx_addr, flg_addr, woke_addr;
    logic [LINK_W-1:0]    nxt_wd, prv_wd, nxt_q, prv_q;
    logic [31:0]          wake_q;
    logic [SLOT_W-1:0]    idx_wd, idx_q;
    logic [1:0]           flg_wd, flg_q;
    logic [TASK_W-1:0]    woke_q;

    logic [TASK_W-1:0]    cur_t;
    logic [SLOT_W-1:0]    file_slot;
    logic [SLOT_W-1:0]    slot_sel;
    logic                 is_new;
    logic                 file_past;
    logic                 linked;
    logic                 p_ok, n_ok, tl_ok;
    logic                 push;
    logic                 can_push;
    logic                 out_free;
    logic                 load_out;
    logic                 drop;
    logic [1:0]           flags_now;
    logic [CNT_W-1:0]     held_dec;

    assign cur_t     = cur_reg[TASK_W-1:0];
    assign is_new    = (op_reg == OP_PAUSE);
    assign file_past = (w_reg != 32'd0) && (w_reg < base_reg);
    assign file_slot = slot_for(w_reg, base_reg);
    assign linked    = (idx_q < NO_SLOT);
    assign p_ok      = (prv_q < LINK_W'(MAX_TASKS));
    assign n_ok      = (nxt_q < LINK_W'(MAX_TASKS));
    assign tl_ok     = (tail_q < LINK_W'(MAX_TASKS));
    assign can_push  = (wn_reg < CNT_W'(MAX_TASKS));
    assign out_free  = !ov_reg || !out_stall;
    assign load_out  = ((cmd.act == A_EMPTY) || (cmd.act == A_EM_WR)) && out_free;
    assign flags_now = fv_reg[cur_t] ? flg_q : FLG_NONE;
    assign held_dec  = (held_reg != '0) ? held_reg - CNT_W'(1) : held_reg;

    always_comb
    begin
        unique case (cmd.phase)
            PH_W3:   slot_sel = SLOT_W'(W1_SLOTS + W2_SLOTS)
                                + SLOT_W'(base_reg >> (W1_BITS + W2_BITS));
            PH_W2:   slot_sel = SLOT_W'(W1_SLOTS)
                                + SLOT_W'(base_reg[W1_BITS+W2_BITS-1:W1_BITS]);
            default: slot_sel = SLOT_W'(base_reg[W1_BITS-1:0]);
        endcase
    end

    always_comb
    begin
        st.op          = op_reg;
        st.valid_id    = ({1'b0, cur_reg} < (LINK_W + 1)'(MAX_TASKS));
        st.present     = st.valid_id && flags_now[0];
        st.running     = flags_now[1];
        st.file_past   = file_past;
        st.file_noslot = (file_slot >= NO_SLOT);
        st.tl_valid    = tl_ok;
        st.loop_ok     = (cur_reg < LINK_W'(MAX_TASKS)) && (guard_reg < CNT_W'(MAX_TASKS));
        st.s1_zero     = (base_reg[W1_BITS-1:0] == '0);
        st.s2_zero     = (base_reg[W1_BITS+W2_BITS-1:W1_BITS] == '0);
        st.s3_ok       = ((base_reg >> (W1_BITS + W2_BITS)) < 32'(W3_SLOTS));
        st.out_free    = out_free;
        st.woke_none   = (wn_reg == '0);
        st.emit_last   = ((k_reg + CNT_W'(1)) == wn_reg);
        st.clear_done  = (clr_reg == LAST_SLOT);
    end

    always_comb
    begin
        head_we   = 1'b0;
        tail_we   = 1'b0;
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        wake_we   = 1'b0;
        idx_we    = 1'b0;
        flg_we    = 1'b0;
        push      = 1'b0;
        drop      = 1'b0;
        head_addr = HS_AW'(slot_sel);
        tail_addr = HS_AW'(slot_sel);
        head_wd   = NIL;
        tail_wd   = NIL;
        nxt_addr  = cur_t;
        prv_addr  = cur_t;
        wake_addr = cur_t;
        idx_addr  = cur_t;
        flg_addr  = cur_t;
        nxt_wd    = NIL;
        prv_wd    = NIL;
        idx_wd    = NO_SLOT;
        flg_wd    = FLG_RUN;
        unique case (cmd.act)
            A_CLEAR:
            begin
                head_we   = 1'b1;
                tail_we   = 1'b1;
                head_addr = clr_reg;
                tail_addr = clr_reg;
            end
            A_ACCEPT:
            begin
                flg_addr = task_id;
            end
            A_UNL_WR:
            begin
                if (linked)
                begin
                    head_addr = HS_AW'(idx_q);
                    tail_addr = HS_AW'(idx_q);
                    idx_we    = 1'b1;
                    drop      = 1'b1;
                    if (p_ok)
                    begin
                        nxt_we   = 1'b1;
                        nxt_addr = prv_q[TASK_W-1:0];
                        nxt_wd   = nxt_q;
                    end
                    else
                    begin
                        head_we = 1'b1;
                        head_wd = nxt_q;
                    end
                    if (n_ok)
                    begin
                        prv_we   = 1'b1;
                        prv_addr = nxt_q[TASK_W-1:0];
                        prv_wd   = prv_q;
                    end
                    else
                    begin
                        tail_we = 1'b1;
                        tail_wd = prv_q;
                    end
                end
            end
            A_PAUSE_WR:
            begin
                flg_we  = 1'b1;
                flg_wd  = FLG_PAUSED;
                wake_we = 1'b1;
            end
            A_FILE:
            begin
                tail_addr = HS_AW'(file_slot);
                if (file_past)
                begin
                    flg_we = 1'b1;
                    idx_we = 1'b1;
                    push   = 1'b1;
                    drop   = !is_new;
                end
                else if (file_slot >= NO_SLOT)
                begin
                    idx_we = 1'b1;
                    drop   = !is_new;
                end
            end
            A_APP_B:
            begin
                head_addr = HS_AW'(slot_reg);
                tail_addr = HS_AW'(slot_reg);
                prv_we    = 1'b1;
                prv_wd    = tail_q;
                idx_we    = 1'b1;
                idx_wd    = slot_reg;
                tail_we   = 1'b1;
                tail_wd   = cur_reg;
                nxt_we    = 1'b1;
                head_we   = !tl_ok;
                head_wd   = cur_reg;
            end
            A_APP_C:
            begin
                nxt_we   = 1'b1;
                nxt_addr = tl_reg[TASK_W-1:0];
                nxt_wd   = cur_reg;
            end
            A_WAKE_ID:
            begin
                flg_we = 1'b1;
                idx_we = 1'b1;
                push   = 1'b1;
            end
            A_REMOVE:
            begin
                flg_we = 1'b1;
                flg_wd = FLG_NONE;
                idx_we = 1'b1;
            end
            A_LIST_CLR:
            begin
                head_we = 1'b1;
                tail_we = 1'b1;
            end
            A_WAKE_T:
            begin
                flg_we = 1'b1;
                idx_we = 1'b1;
                push   = 1'b1;
                drop   = 1'b1;
            end
            default:
            begin
            end
        endcase
        woke_we   = push && can_push;
        woke_addr = push ? wn_reg[TASK_W-1:0] : k_reg[TASK_W-1:0];
    end

    ttw_ram #(.WIDTH(LINK_W), .DEPTH(NSLOTS)) u_head (
        .clk(clk), .we(head_we), .addr(head_addr), .wdata(head_wd), .rdata(head_q));
    ttw_ram #(.WIDTH(LINK_W), .DEPTH(NSLOTS)) u_tail (
        .clk(clk), .we(tail_we), .addr(tail_addr), .wdata(tail_wd), .rdata(tail_q));
    ttw_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TASKS)) u_next (
        .clk(clk), .we(nxt_we), .addr(nxt_addr), .wdata(nxt_wd), .rdata(nxt_q));
    ttw_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TASKS)) u_prev (
        .clk(clk), .we(prv_we), .addr(prv_addr), .wdata(prv_wd), .rdata(prv_q));
    ttw_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_wake (
        .clk(clk), .we(wake_we), .addr(wake_addr), .wdata(win_reg), .rdata(wake_q));
    ttw_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS)) u_idx (
        .clk(clk), .we(idx_we), .addr(idx_addr), .wdata(idx_wd), .rdata(idx_q));
    ttw_ram #(.WIDTH(2), .DEPTH(MAX_TASKS)) u_flags (
        .clk(clk), .we(flg_we), .addr(flg_addr), .wdata(flg_wd), .rdata(flg_q));
    ttw_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_woke (
        .clk(clk), .we(woke_we), .addr(woke_addr), .wdata(cur_t), .rdata(woke_q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            base_reg <= '0;
            held_reg <= '0;
            wn_reg   <= '0;
            fv_reg   <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.act == A_CLEAR)
                clr_reg <= clr_reg + HS_AW'(1);
            if (cmd.act == A_BASE_INC)
                base_reg <= base_reg + 32'd1;
            if (flg_we)
                fv_reg[cur_t] <= 1'b1;
            if (cmd.act == A_ACCEPT)
                wn_reg <= '0;
            else if (woke_we)
                wn_reg <= wn_reg + CNT_W'(1);
            if (drop)
                held_reg <= held_dec;
            else if ((cmd.act == A_APP_B) && is_new)
                held_reg <= held_reg + CNT_W'(1);
            if (load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.act)
            A_ACCEPT:
            begin
                op_reg   <= opcode;
                cur_reg  <= {1'b0, task_id};
                win_reg  <= wake_time;
                stat_reg <= ST_OK;
            end
            A_DECODE:
            begin
                if (((op_reg == OP_PAUSE) || (op_reg == OP_REMOVE)) && !st.present)
                    stat_reg <= ST_ABSENT;
                else if ((op_reg == OP_RUN) && !st.valid_id)
                    stat_reg <= ST_ABSENT;
            end
            A_PAUSE_WR:
            begin
                w_reg <= win_reg;
            end
            A_FILE:
            begin
                slot_reg <= file_slot;
                if (!file_past && (file_slot >= NO_SLOT) && is_new)
                    stat_reg <= ST_FAR;
            end
            A_APP_B:
            begin
                tl_reg <= tail_q;
            end
            A_LIST_CLR:
            begin
                cur_reg   <= head_q;
                guard_reg <= '0;
            end
            A_MIG_T:
            begin
                nxt_reg <= nxt_q;
                w_reg   <= wake_q;
            end
            A_MIG_NEXT:
            begin
                cur_reg   <= nxt_reg;
                guard_reg <= guard_reg + CNT_W'(1);
            end
            A_WAKE_T:
            begin
                cur_reg   <= nxt_q;
                guard_reg <= guard_reg + CNT_W'(1);
            end
            A_DONE:
            begin
                k_reg <= '0;
            end
            A_EMPTY:
            begin
                if (out_free)
                begin
                    otask_reg  <= '0;
                    owoken_reg <= 1'b0;
                    olast_reg  <= 1'b1;
                end
            end
            A_EM_WR:
            begin
                if (out_free)
                begin
                    otask_reg  <= woke_q;
                    owoken_reg <= 1'b1;
                    olast_reg  <= st.emit_last;
                    k_reg      <= k_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // status, count and base are final for the request once results go out
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status       <= stat_reg;
            paused_count <= held_reg;
            current_base <= base_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign woken_task = otask_reg;
    assign woken      = owoken_reg;
    assign last       = olast_reg;

endmodule

FILE: design/three_level_timer_wheel_unit.sv
// three-level timer wheel: task lists in slot memories, sequenced one request at a time
// pause/resume/remove: list edits, then a result per woken task, or one empty result
// advance: visits the due slot of each level, coarsest first, moving tasks to finer slots,
// waking those in the level-1 slot, then steps the base and gives results the same way
// one request in flight; the next is taken the cycle after its last result is loaded
// reset: async, active low; a clearing pass empties all 5185 slot lists, stall high
module three_level_timer_wheel_unit
    import ttw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [TASK_W-1:0] task_id,
    input  logic [31:0]       wake_time,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TASK_W-1:0] woken_task,
    output logic              woken,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  paused_count,
    output logic [31:0]       current_base,
    output logic              last
);

    cmd_t  cmd;
    stat_t st;

    ttw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ttw_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .opcode       (opcode),
        .task_id      (task_id),
        .wake_time    (wake_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .woken_task   (woken_task),
        .woken        (woken),
        .status       (status),
        .paused_count (paused_count),
        .current_base (current_base),
        .last         (last)
    );

endmodule

FILE: design/ttw_checker.sv
// port-level checks for the timer wheel unit, bound to the top level
module ttw_assertions
    import ttw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [TASK_W-1:0] woken_task,
    input logic              woken,
    input logic [CNT_W-1:0]  paused_count,
    input logic              last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(woken_task) && $stable(last))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !woken |-> last && (woken_task == '0))
        else $error("result without a woken task must be the only one");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> paused_count <= CNT_W'(MAX_TASKS))
        else $error("paused count above task limit");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while previous one in progress");

    // while a result that is not the last one is shown, the unit stays busy
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("new request taken before all results of the previous one");

endmodule

bind three_level_timer_wheel_unit ttw_assertions u_ttw_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .woken_task   (woken_task),
    .woken        (woken),
    .paused_count (paused_count),
    .last         (last)
);
